// ===== hw/rtl/epu_pkg.sv =====
// Package with action codes, register indexes and pipeline types of the eikonal point update.
`timescale 1ns / 1ps
package epu_pkg;

    localparam logic [2:0] ACT_OBSTACLE = 3'd0;
    localparam logic [2:0] ACT_BOUNDARY = 3'd1;
    localparam logic [2:0] ACT_ONE      = 3'd2;
    localparam logic [2:0] ACT_TWO      = 3'd3;
    localparam logic [2:0] ACT_THREE    = 3'd4;
    localparam logic [2:0] ACT_REJECT   = 3'd5;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_GAIN      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_VALUE       = 4'd3;

    // square root state: radicand bits still to consume, partial remainder, root
    typedef struct packed {
        logic [63:0] rad;
        logic [35:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic        obst;
        logic        bnd;
        logic [31:0] bval;
        logic [31:0] old;
        logic [31:0] prev;
        logic [31:0] fine;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [51:0] prod;
        logic [30:0] rh;
        logic [31:0] dab;
        logic [31:0] dbc;
        logic [31:0] dac;
        logic [33:0] u1;
        logic        ok1;
        logic [32:0] sab;
        logic [33:0] sabc;
        logic [61:0] rh2;
        logic [63:0] sqab;
        logic [63:0] sqbc;
        logic [63:0] sqac;
        logic [62:0] two;
        logic [63:0] three;
        logic [63:0] ssp;
        logic [63:0] ss;
        logic        ok2;
        logic        ok3;
        logic [63:0] rad2;
        logic [63:0] rad3;
        logic [33:0] u2;
        logic        neg3;
        logic [34:0] mag3;
        logic [34:0] q3;
        logic [1:0]  rem3;
        logic [35:0] u3;
        logic        ok2c;
        logic        ok3c;
        logic [2:0]  act;
        logic [31:0] u;
        logic [32:0] diff;
        logic [30:0] ch;
        logic        match;
        logic [64:0] prodc;
        logic [2:0]  oact;
        logic [31:0] ocv;
        logic [31:0] osol;
        logic [30:0] ochg;
    } t_ctx;

endpackage

// ===== hw/rtl/eikonal_point_update.sv =====
// Pipelined Godunov upwind local solve of one 3D eikonal grid point with parareal correction.
`timescale 1ns / 1ps
// The block takes one grid point in every cycle (start while busy is low; busy never rises)
// and gives its result at the end of the pipeline as a one-cycle o_valid strobe that cannot be held
// off. The pipeline depth is set by the two 32-step square root units (four steps per stage),
// which run side by side, and the divide by three (seven quotient bits per stage) after them.
// Write configuration registers only while no point is in flight.
module eikonal_point_update #(
    parameter int FRAC_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_is_obstacle,
    input  logic [31:0]                   i_boundary_value,
    input  logic [30:0]                   i_slowness,
    input  logic [31:0]                   i_nb_x_minus,
    input  logic [31:0]                   i_nb_x_plus,
    input  logic [31:0]                   i_nb_y_minus,
    input  logic [31:0]                   i_nb_y_plus,
    input  logic [31:0]                   i_nb_z_minus,
    input  logic [31:0]                   i_nb_z_plus,
    input  logic [31:0]                   i_old_value,
    input  logic [31:0]                   i_coarse_prev,
    input  logic [31:0]                   i_fine_value,
    output logic                          o_valid,
    output logic [2:0]                    o_point_action,
    output logic [31:0]                   o_coarse_value,
    output logic [31:0]                   o_coarse_solution,
    output logic [30:0]                   o_value_change,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [epu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import epu_pkg::*;

    localparam int LAST   = 24;
    localparam int SQ0    = 7;
    localparam int SQ1    = 14;
    localparam int SQ_STEPS = 4;
    localparam int DIV0   = 16;
    localparam int DIV1   = 20;
    localparam int DIV_STEPS = 7;
    localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] I32_MAX = 65'sd2147483647;
    localparam logic signed [64:0] I32_MIN = -65'sd2147483648;

    logic [20:0] r_grid;
    logic [30:0] r_gain;
    logic [20:0] r_tol;
    logic [30:0] r_cap;

    t_ctx r_ctx [1:LAST];
    t_ctx n_ctx [1:LAST];
    logic r_vld [1:LAST];
    t_sq  r_sq2 [SQ0:SQ1];
    t_sq  r_sq3 [SQ0:SQ1];
    t_sq  n_sq2 [SQ0:SQ1];
    t_sq  n_sq3 [SQ0:SQ1];

    function automatic logic [31:0] smin(input logic [31:0] x, input logic [31:0] y);
        smin = ($signed(x) < $signed(y)) ? x : y;
    endfunction

    function automatic logic [31:0] smax(input logic [31:0] x, input logic [31:0] y);
        smax = ($signed(x) > $signed(y)) ? x : y;
    endfunction

    function automatic t_sq sq_step(input t_sq x);
        t_sq         y;
        logic [35:0] rn;
        logic [35:0] trial;
        rn    = {x.rem[33:0], x.rad[63:62]};
        trial = {2'b00, x.root, 2'b01};
        y.rad = {x.rad[61:0], 2'b00};
        if (rn >= trial) begin
            y.rem  = rn - trial;
            y.root = {x.root[30:0], 1'b1};
        end else begin
            y.rem  = rn;
            y.root = {x.root[30:0], 1'b0};
        end
        sq_step = y;
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= 21'd65536;
            r_gain <= 31'd1048576;
            r_tol  <= 21'd0;
            r_cap  <= 31'd1048576000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_SPACING:    r_grid <= i_cfg_data[20:0];
                CFG_RELAX_GAIN:      r_gain <= i_cfg_data[30:0];
                CFG_MATCH_TOLERANCE: r_tol  <= i_cfg_data[20:0];
                CFG_CAP_VALUE:       r_cap  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        t_ctx        p;
        t_sq         s2;
        t_sq         s3;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] m3;
        logic [51:0] sh;
        logic [64:0] w65;
        logic [33:0] sum2;
        logic [34:0] sum3;
        logic [2:0]  t;
        logic [32:0] dd;
        logic [32:0] cd;
        logic signed [64:0] rs;

        // stage 1: axis minima, sort, slowness times spacing
        p = '0;
        p.obst = i_is_obstacle;
        p.bnd  = ~i_boundary_value[31];
        p.bval = i_boundary_value;
        p.old  = i_old_value;
        p.prev = i_coarse_prev;
        p.fine = i_fine_value;
        m1 = smin(i_nb_x_minus, i_nb_x_plus);
        m2 = smin(i_nb_y_minus, i_nb_y_plus);
        m3 = smin(i_nb_z_minus, i_nb_z_plus);
        p.a = smin(m1, smin(m2, m3));
        p.c = smax(m1, smax(m2, m3));
        p.b = smax(smin(m1, m2), smin(smax(m1, m2), m3));
        p.prod = {21'd0, i_slowness} * {31'd0, r_grid};
        n_ctx[1] = p;

        // stage 2: saturated R*H, gaps between sorted minima, sums of the minima, one-sided solve
        p = r_ctx[1];
        sh = p.prod >> FRAC_BITS;
        p.rh = (|sh[51:31]) ? 31'h7FFF_FFFF : sh[30:0];
        p.dab = p.b - p.a;
        p.dbc = p.c - p.b;
        p.dac = p.c - p.a;
        p.u1  = {{2{p.a[31]}}, p.a} + {3'd0, p.rh};
        p.ok1 = $signed(p.u1) <= $signed({{2{p.b[31]}}, p.b});
        p.sab = {p.a[31], p.a} + {p.b[31], p.b};
        p.sabc = {{2{p.a[31]}}, p.a} + {{2{p.b[31]}}, p.b} + {{2{p.c[31]}}, p.c};
        n_ctx[2] = p;

        // stage 3: squares
        p = r_ctx[2];
        p.rh2  = {31'd0, p.rh} * {31'd0, p.rh};
        p.sqab = {32'd0, p.dab} * {32'd0, p.dab};
        p.sqbc = {32'd0, p.dbc} * {32'd0, p.dbc};
        p.sqac = {32'd0, p.dac} * {32'd0, p.dac};
        n_ctx[3] = p;

        // stage 4: scaled R*H squared, first part of the gap sum
        p = r_ctx[3];
        p.two   = {p.rh2, 1'b0};
        p.three = {2'b00, p.rh2} + {1'b0, p.rh2, 1'b0};
        w65 = {1'b0, p.sqab} + {1'b0, p.sqbc};
        p.ssp = w65[64] ? '1 : w65[63:0];
        n_ctx[4] = p;

        // stage 5: finish gap sum, two-sided discriminant
        p = r_ctx[4];
        w65 = {1'b0, p.ssp} + {1'b0, p.sqac};
        p.ss   = w65[64] ? '1 : w65[63:0];
        p.ok2  = p.sqab <= {1'b0, p.two};
        p.rad2 = {1'b0, p.two} - p.sqab;
        n_ctx[5] = p;

        // stage 6: three-sided discriminant
        p = r_ctx[5];
        p.ok3  = p.ss <= p.three;
        p.rad3 = p.three - p.ss;
        n_ctx[6] = p;

        // square root stages: four root bits per stage
        for (int k = SQ0; k <= SQ1; k++) begin
            n_ctx[k] = r_ctx[k-1];
            if (k == SQ0) begin
                s2 = '{rad: r_ctx[k-1].rad2, rem: '0, root: '0};
                s3 = '{rad: r_ctx[k-1].rad3, rem: '0, root: '0};
            end else begin
                s2 = r_sq2[k-1];
                s3 = r_sq3[k-1];
            end
            for (int j = 0; j < SQ_STEPS; j++) begin
                s2 = sq_step(s2);
                s3 = sq_step(s3);
            end
            n_sq2[k] = s2;
            n_sq3[k] = s3;
        end

        // stage 15: halve two-sided sum, split three-sided sum into sign and magnitude
        p = r_ctx[SQ1];
        sum2 = {p.sab[32], p.sab} + {2'b00, r_sq2[SQ1].root};
        sum2 = sum2 + {33'd0, sum2[33]};
        p.u2 = {sum2[33], sum2[33:1]};
        sum3 = {p.sabc[33], p.sabc} + {3'b000, r_sq3[SQ1].root};
        p.neg3 = sum3[34];
        p.mag3 = sum3[34] ? (35'd0 - sum3) : sum3;
        p.q3   = '0;
        p.rem3 = '0;
        n_ctx[SQ1+1] = p;

        // divide by three, seven quotient bits per stage
        for (int k = DIV0; k <= DIV1; k++) begin
            p = r_ctx[k-1];
            for (int j = 0; j < DIV_STEPS; j++) begin
                t = {p.rem3, p.mag3[34]};
                p.mag3 = {p.mag3[33:0], 1'b0};
                if (t >= 3'd3) begin
                    p.rem3 = 2'(t - 3'd3);
                    p.q3   = {p.q3[33:0], 1'b1};
                end else begin
                    p.rem3 = t[1:0];
                    p.q3   = {p.q3[33:0], 1'b0};
                end
            end
            n_ctx[k] = p;
        end

        // stage 21: restore sign, acceptance compares
        p = r_ctx[DIV1];
        p.u3   = p.neg3 ? (36'd0 - {1'b0, p.q3}) : {1'b0, p.q3};
        p.ok3c = $signed(p.u3) < $signed({5'd0, r_cap});
        p.ok2c = $signed(p.u2) <= $signed({{2{p.c[31]}}, p.c});
        n_ctx[21] = p;

        // stage 22: pick the solve, differences against previous and old values
        p = r_ctx[21];
        priority if (p.obst) begin
            p.act = ACT_OBSTACLE;
            p.u   = '0;
        end else if (p.bnd) begin
            p.act = ACT_BOUNDARY;
            p.u   = '0;
        end else if (p.ok1) begin
            p.act = ACT_ONE;
            p.u   = p.u1[31:0];
        end else if (p.ok2 && p.ok2c) begin
            p.act = ACT_TWO;
            p.u   = p.u2[31:0];
        end else if (p.ok3 && p.ok3c) begin
            p.act = ACT_THREE;
            p.u   = p.u3[31:0];
        end else begin
            p.act = ACT_REJECT;
            p.u   = '0;
        end
        p.diff = {p.u[31], p.u} - {p.prev[31], p.prev};
        dd = p.diff[32] ? (33'd0 - p.diff) : p.diff;
        p.match = dd <= {12'd0, r_tol};
        cd = {p.u[31], p.u} - {p.old[31], p.old};
        cd = cd[32] ? (33'd0 - cd) : cd;
        p.ch = (|cd[32:31]) ? 31'h7FFF_FFFF : cd[30:0];
        n_ctx[22] = p;

        // stage 23: gain times difference
        p = r_ctx[22];
        p.prodc = $signed({34'd0, r_gain}) * $signed({{32{p.diff[32]}}, p.diff});
        n_ctx[23] = p;

        // stage 24: round, add fine value, saturate, build the result word
        p = r_ctx[23];
        rs = ($signed(p.prodc) + RND) >>> FRAC_BITS;
        rs = rs + $signed({{33{p.fine[31]}}, p.fine});
        if (rs > I32_MAX) begin
            rs = I32_MAX;
        end else if (rs < I32_MIN) begin
            rs = I32_MIN;
        end
        p.oact = p.act;
        p.ocv  = p.old;
        p.osol = '0;
        p.ochg = '0;
        unique case (p.act)
            ACT_OBSTACLE, ACT_REJECT: ;
            ACT_BOUNDARY: p.ocv = p.bval;
            ACT_ONE, ACT_TWO, ACT_THREE: begin
                p.ocv  = p.match ? p.fine : rs[31:0];
                p.osol = p.u;
                p.ochg = p.ch;
            end
            default: ;
        endcase
        n_ctx[LAST] = p;
    end

    // valid bits advance every cycle; the receiver never stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[1] <= start;
            for (int k = 2; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= LAST; k++) begin
            r_ctx[k] <= n_ctx[k];
        end
        for (int k = SQ0; k <= SQ1; k++) begin
            r_sq2[k] <= n_sq2[k];
            r_sq3[k] <= n_sq3[k];
        end
    end

    assign o_valid           = r_vld[LAST];
    assign o_point_action    = r_ctx[LAST].oact;
    assign o_coarse_value    = r_ctx[LAST].ocv;
    assign o_coarse_solution = r_ctx[LAST].osol;
    assign o_value_change    = r_ctx[LAST].ochg;

    a_start_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_vld[1])
        else $error("accepted word did not enter the pipeline");

    a_obst_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && r_ctx[1].obst) |-> ##(LAST-1) (o_valid && o_point_action == ACT_OBSTACLE))
        else $error("obstacle word lost or misclassified");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point_action == ACT_REJECT) |->
            (o_coarse_solution == 32'd0 && o_value_change == 31'd0))
        else $error("rejected solve carries a solution");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_point_action == ACT_OBSTACLE || o_point_action == ACT_BOUNDARY)) |->
            (o_coarse_solution == 32'd0 && o_value_change == 31'd0))
        else $error("skipped point carries a solution");

endmodule
